// File: src/lct_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lct_pkg
// Shared types, constants and the blend function of the 3D LUT color grader.
// ----------------------------------------------------------------------------
package lct_pkg;

	localparam int FRAC_BITS = 12;
	localparam int VAL_W     = FRAC_BITS + 1;
	localparam int ONE       = 1 << FRAC_BITS;
	localparam int TABLE_DIM_DEF = 16;

	// request kinds
	localparam logic REQ_GRADE = 1'b0;
	localparam logic REQ_WRITE = 1'b1;

	typedef struct packed {
		logic             req_type;
		logic [15:0]      red_in;
		logic [15:0]      green_in;
		logic [15:0]      blue_in;
		logic [11:0]      entry_index;
		logic [VAL_W-1:0] entry_red;
		logic [VAL_W-1:0] entry_green;
		logic [VAL_W-1:0] entry_blue;
	} req_t;

	typedef struct packed {
		logic [VAL_W-1:0] red_out;
		logic [VAL_W-1:0] green_out;
		logic [VAL_W-1:0] blue_out;
	} res_t;

	// one table entry, red in the top bits
	typedef logic [3*VAL_W-1:0] entry_t;

	// a*(1-f) + b*f, each product truncated on its own
	function automatic logic [VAL_W-1:0] blend(input logic [VAL_W-1:0] a,
			input logic [VAL_W-1:0] b, input logic [FRAC_BITS-1:0] f);
		logic [VAL_W-1:0]     nf;
		logic [2*VAL_W-1:0]   pa;
		logic [2*VAL_W-1:0]   pb;
		logic [VAL_W:0]       sum;
		nf  = VAL_W'(ONE) - {1'b0, f};
		pa  = a * nf;
		pb  = b * {1'b0, f};
		sum = (VAL_W+1)'(pa >> FRAC_BITS) + (VAL_W+1)'(pb >> FRAC_BITS);
		return sum[VAL_W-1:0];
	endfunction

endpackage

// File: src/lct_mem.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lct_mem
// One copy of the grade table: one write port, two registered read ports.
// ----------------------------------------------------------------------------
module lct_mem
	import lct_pkg::*;
#(
	parameter int DEPTH  = 4096,
	parameter int ADDR_W = 12
) (
	input  logic              clk,
	input  logic              en,
	input  logic              we,
	input  logic [ADDR_W-1:0] waddr,
	input  entry_t            wdata,
	input  logic [ADDR_W-1:0] raddr_a,
	input  logic [ADDR_W-1:0] raddr_b,
	output entry_t            rdata_a,
	output entry_t            rdata_b
);

	entry_t mem_q [DEPTH];

	// write new entry
	always_ff @(posedge clk) begin
		if (we)
			mem_q[waddr] <= wdata;
	end

	// read both corners, hold on stall
	always_ff @(posedge clk) begin
		if (en) begin
			rdata_a <= mem_q[raddr_a];
			rdata_b <= mem_q[raddr_b];
		end
	end

endmodule

// File: src/lct_interp.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lct_interp
// Trilinear blend over three stages: along red, then green, then blue.
// ----------------------------------------------------------------------------
module lct_interp
	import lct_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 en,
	input  logic                 valid_s2,
	input  entry_t               corner_s2 [8],
	input  logic [FRAC_BITS-1:0] fr_s2,
	input  logic [FRAC_BITS-1:0] fg_s2,
	input  logic [FRAC_BITS-1:0] fb_s2,
	output logic                 valid_s5,
	output res_t                 res_s5
);

	logic                 valid_s3, valid_s4;
	logic [VAL_W-1:0]     c_s3 [3][4];
	logic [VAL_W-1:0]     c_s4 [3][2];
	logic [FRAC_BITS-1:0] fg_s3, fb_s3, fb_s4;
	logic [VAL_W-1:0]     o_s5 [3];

	// advance valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s3 <= 1'b0;
			valid_s4 <= 1'b0;
			valid_s5 <= 1'b0;
		end else if (en) begin
			valid_s3 <= valid_s2;
			valid_s4 <= valid_s3;
			valid_s5 <= valid_s4;
		end
	end

	// blend stages; corner k holds g/b select k, pair (2k, 2k+1) is r0/r1
	always_ff @(posedge clk) begin
		if (en) begin
			for (int ch = 0; ch < 3; ch++) begin
				for (int k = 0; k < 4; k++)
					c_s3[ch][k] <= blend(corner_s2[2*k][(2-ch)*VAL_W +: VAL_W],
						corner_s2[2*k+1][(2-ch)*VAL_W +: VAL_W], fr_s2);
				c_s4[ch][0] <= blend(c_s3[ch][0], c_s3[ch][2], fg_s3);
				c_s4[ch][1] <= blend(c_s3[ch][1], c_s3[ch][3], fg_s3);
				o_s5[ch]    <= blend(c_s4[ch][0], c_s4[ch][1], fb_s4);
			end
			fg_s3 <= fg_s2;
			fb_s3 <= fb_s2;
			fb_s4 <= fb_s3;
		end
	end

	assign res_s5.red_out   = o_s5[0];
	assign res_s5.green_out = o_s5[1];
	assign res_s5.blue_out  = o_s5[2];

endmodule

// File: src/lut3d_trilinear_color_grade.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lut3d_trilinear_color_grade
// 3D LUT color grader with trilinear interpolation.
// ----------------------------------------------------------------------------
// Takes one item per clock: either a table write (no result) or a pixel whose
// graded RGB result passes stage 1, the table read and the blend stages. The
// table is held in four copies, each read at two corners per cycle, so all
// eight corners come out in one registered read; every write goes to all
// copies. The pipeline stalls as a whole when the result register is full
// and not taken. Entries must be written before a pixel reads them.
// ----------------------------------------------------------------------------
module lut3d_trilinear_color_grade
	import lct_pkg::*;
#(
	parameter int TABLE_DIM = TABLE_DIM_DEF
) (
	input  logic clk,
	input  logic arst_n,
	input  logic req_valid,
	output logic req_ready,
	input  req_t req,
	output logic res_valid,
	input  logic res_ready,
	output res_t res
);

	localparam int IDX_W   = $clog2(TABLE_DIM);
	localparam int SC_W    = VAL_W + IDX_W;
	localparam int ENTRIES = TABLE_DIM * TABLE_DIM * TABLE_DIM;
	localparam int ADDR_W  = $clog2(ENTRIES);

	logic                 en;
	logic                 valid_s1, valid_s2, valid_s5;
	logic                 type_s1;
	logic [SC_W-1:0]      sc_s1 [3];
	logic [11:0]          widx_s1;
	entry_t               wdata_s1;
	logic [IDX_W-1:0]     lo [3];
	logic [IDX_W-1:0]     hi [3];
	logic [ADDR_W-1:0]    ra [8];
	logic                 we;
	logic [FRAC_BITS-1:0] fr_s2, fg_s2, fb_s2;
	entry_t               corner_s2 [8];
	logic [15:0]          chan [3];
	logic [VAL_W-1:0]     sat [3];

	assign en        = !valid_s5 || res_ready;
	assign req_ready = en;
	assign res_valid = valid_s5;

	// clamp channels to 1.0
	assign chan[0] = req.red_in;
	assign chan[1] = req.green_in;
	assign chan[2] = req.blue_in;
	always_comb begin
		for (int i = 0; i < 3; i++)
			sat[i] = (chan[i] > 16'(ONE)) ? VAL_W'(ONE) : chan[i][VAL_W-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else if (en) begin
			valid_s1 <= req_valid;
			valid_s2 <= valid_s1 && (type_s1 == REQ_GRADE);
		end
	end

	// stage 1: scale channels, saturate write data
	always_ff @(posedge clk) begin
		if (en) begin
			type_s1 <= req.req_type;
			widx_s1 <= req.entry_index;
			wdata_s1 <= {
				(req.entry_red   > VAL_W'(ONE)) ? VAL_W'(ONE) : req.entry_red,
				(req.entry_green > VAL_W'(ONE)) ? VAL_W'(ONE) : req.entry_green,
				(req.entry_blue  > VAL_W'(ONE)) ? VAL_W'(ONE) : req.entry_blue};
			for (int i = 0; i < 3; i++)
				sc_s1[i] <= SC_W'(sat[i]) * SC_W'(TABLE_DIM - 1);
		end
	end

	// split into corner indices
	always_comb begin
		for (int i = 0; i < 3; i++) begin
			lo[i] = (sc_s1[i][SC_W-1:FRAC_BITS] > (IDX_W+1)'(TABLE_DIM - 1))
				? IDX_W'(TABLE_DIM - 1) : sc_s1[i][FRAC_BITS +: IDX_W];
			hi[i] = (32'(lo[i]) + 1 < TABLE_DIM) ? lo[i] + IDX_W'(1) : lo[i];
		end
		for (int k = 0; k < 8; k++)
			ra[k] = ADDR_W'(((32'(k[0] ? hi[0] : lo[0]) * TABLE_DIM
				+ 32'(k[2] ? hi[1] : lo[1])) * TABLE_DIM)
				+ 32'(k[1] ? hi[2] : lo[2]));
	end

	// write leaves stage 1; out-of-range index is dropped
	assign we = en && valid_s1 && (type_s1 == REQ_WRITE) && (32'(widx_s1) < ENTRIES);

	always_ff @(posedge clk) begin
		if (en) begin
			fr_s2 <= sc_s1[0][FRAC_BITS-1:0];
			fg_s2 <= sc_s1[1][FRAC_BITS-1:0];
			fb_s2 <= sc_s1[2][FRAC_BITS-1:0];
		end
	end

	// four table copies, corners (2k, 2k+1) differ in red only
	for (genvar k = 0; k < 4; k++) begin : g_mem
		lct_mem #(
			.DEPTH  (ENTRIES),
			.ADDR_W (ADDR_W)
		) u_mem (
			.clk     (clk),
			.en      (en),
			.we      (we),
			.waddr   (ADDR_W'(widx_s1)),
			.wdata   (wdata_s1),
			.raddr_a (ra[2*k]),
			.raddr_b (ra[2*k+1]),
			.rdata_a (corner_s2[2*k]),
			.rdata_b (corner_s2[2*k+1])
		);
	end

	lct_interp u_interp (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.valid_s2  (valid_s2),
		.corner_s2 (corner_s2),
		.fr_s2     (fr_s2),
		.fg_s2     (fg_s2),
		.fb_s2     (fb_s2),
		.valid_s5  (valid_s5),
		.res_s5    (res)
	);

endmodule

// File: tb/sv/lut3d_trilinear_color_grade_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lut3d_trilinear_color_grade_test
// Self-checking bench for the 3D LUT trilinear color grader.
// ----------------------------------------------------------------------------
// Drives table writes and pixels over the request channel. A local copy of the
// table predicts each graded pixel. Every result is checked against the
// oldest expected result. Pixels are only sent once all eight corner entries
// they read hold a written value; missing corners are written first. Both
// channels idle in random bursts. One long receiver hold-off fills the
// pipeline, and one sender pause lets it drain. The last part runs with no
// idling.
// ----------------------------------------------------------------------------
module lut3d_trilinear_color_grade_test;
	import lct_pkg::*;

	localparam int DIM       = 16;
	localparam int ENTRIES   = DIM * DIM * DIM;
	localparam int N_ITEMS   = 1500;
	localparam int MAX_CYC   = 600000;
	localparam int HOLD_CYC  = 200;
	localparam int DRAIN_CYC = 20;

	typedef struct {
		req_t item;
		bit   typed;
		res_t want;
	} stim_row_t;

	logic clk;
	logic arst_n;
	logic req_valid;
	logic req_ready;
	req_t req;
	logic res_valid;
	logic res_ready;
	res_t res;

	// table copy
	logic [VAL_W-1:0] lut_r [ENTRIES];
	logic [VAL_W-1:0] lut_g [ENTRIES];
	logic [VAL_W-1:0] lut_b [ENTRIES];
	bit               lut_set [ENTRIES];

	res_t graded_q [$];
	int   mismatches;
	int   sent;
	int   cycles;
	bit   idle_on;
	bit   hold_req;

	lut3d_trilinear_color_grade dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_ready (req_ready),
		.req       (req),
		.res_valid (res_valid),
		.res_ready (res_ready),
		.res       (res)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	function automatic int sat_val(int v);
		return (v > ONE) ? ONE : v;
	endfunction

	// lower index, upper index and fraction of one channel
	function automatic void axis_split(input int chan, output int lo, output int hi,
			output int fr);
		int scaled;
		scaled = sat_val(chan) * (DIM - 1);
		lo = scaled >> FRAC_BITS;
		if (lo > DIM - 1)
			lo = DIM - 1;
		hi = (lo + 1 < DIM) ? lo + 1 : lo;
		fr = scaled & (ONE - 1);
	endfunction

	function automatic int mix(int a, int b, int f);
		return ((a * (ONE - f)) >> FRAC_BITS) + ((b * f) >> FRAC_BITS);
	endfunction

	function automatic int corner_idx(int r, int g, int b);
		return (r * DIM + g) * DIM + b;
	endfunction

	function automatic int lut_val(int idx, int ch);
		case (ch)
			0: return lut_r[idx];
			1: return lut_g[idx];
			default: return lut_b[idx];
		endcase
	endfunction

	function automatic res_t grade_pixel(req_t p);
		int r0, r1, fr, g0, g1, fg, b0, b1, fb;
		int c00, c01, c10, c11, c0, c1;
		int v [3];
		res_t o;
		axis_split(p.red_in, r0, r1, fr);
		axis_split(p.green_in, g0, g1, fg);
		axis_split(p.blue_in, b0, b1, fb);
		for (int ch = 0; ch < 3; ch++) begin
			c00 = mix(lut_val(corner_idx(r0, g0, b0), ch), lut_val(corner_idx(r1, g0, b0), ch), fr);
			c01 = mix(lut_val(corner_idx(r0, g0, b1), ch), lut_val(corner_idx(r1, g0, b1), ch), fr);
			c10 = mix(lut_val(corner_idx(r0, g1, b0), ch), lut_val(corner_idx(r1, g1, b0), ch), fr);
			c11 = mix(lut_val(corner_idx(r0, g1, b1), ch), lut_val(corner_idx(r1, g1, b1), ch), fr);
			c0 = mix(c00, c10, fg);
			c1 = mix(c01, c11, fg);
			v[ch] = mix(c0, c1, fb);
		end
		o.red_out   = v[0][VAL_W-1:0];
		o.green_out = v[1][VAL_W-1:0];
		o.blue_out  = v[2][VAL_W-1:0];
		return o;
	endfunction

	function automatic req_t rand_req();
		req_t r;
		r = req_t'({$urandom, $urandom, $urandom});
		return r;
	endfunction

	function automatic req_t mk_write(int idx, int rv, int gv, int bv);
		req_t r;
		r = rand_req();
		r.req_type    = REQ_WRITE;
		r.entry_index = idx[11:0];
		r.entry_red   = rv[VAL_W-1:0];
		r.entry_green = gv[VAL_W-1:0];
		r.entry_blue  = bv[VAL_W-1:0];
		return r;
	endfunction

	function automatic req_t mk_pixel(int rv, int gv, int bv);
		req_t r;
		r = rand_req();
		r.req_type = REQ_GRADE;
		r.red_in   = rv[15:0];
		r.green_in = gv[15:0];
		r.blue_in  = bv[15:0];
		return r;
	endfunction

	function automatic res_t mk_res(int rv, int gv, int bv);
		res_t o;
		o.red_out   = rv[VAL_W-1:0];
		o.green_out = gv[VAL_W-1:0];
		o.blue_out  = bv[VAL_W-1:0];
		return o;
	endfunction

	// random entry value, saturating now and then
	function automatic int rand_entry_val();
		return ($urandom_range(0, 7) == 0) ? $urandom_range(ONE, 8191) : $urandom_range(0, ONE);
	endfunction

	// offer one item, hold it until accepted, then update the table copy
	task automatic send_item(req_t r, bit typed, res_t want);
		int gap;
		if (idle_on && $urandom_range(0, 5) == 0) begin
			gap = $urandom_range(1, 10);
			req_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		req_valid <= 1'b1;
		req       <= r;
		do @(posedge clk); while (!req_ready);
		sent++;
		if (r.req_type == REQ_WRITE) begin
			lut_r[r.entry_index]   = sat_val(r.entry_red);
			lut_g[r.entry_index]   = sat_val(r.entry_green);
			lut_b[r.entry_index]   = sat_val(r.entry_blue);
			lut_set[r.entry_index] = 1'b1;
		end else begin
			graded_q.push_back(typed ? want : grade_pixel(r));
		end
	endtask

	// write any unwritten corner of a pixel, then grade it
	task automatic send_pixel_safe(req_t p);
		int r0, r1, fr, g0, g1, fg, b0, b1, fb;
		int idx;
		res_t none;
		none = '0;
		axis_split(p.red_in, r0, r1, fr);
		axis_split(p.green_in, g0, g1, fg);
		axis_split(p.blue_in, b0, b1, fb);
		for (int k = 0; k < 8; k++) begin
			idx = corner_idx(k[0] ? r1 : r0, k[1] ? g1 : g0, k[2] ? b1 : b0);
			if (!lut_set[idx])
				send_item(mk_write(idx, rand_entry_val(), rand_entry_val(), rand_entry_val()),
					1'b0, none);
		end
		send_item(p, 1'b0, none);
	endtask

	function automatic int rand_chan();
		int sel;
		sel = $urandom_range(0, 19);
		if (sel == 0)
			return $urandom_range(0, 65535);
		if (sel == 1)
			return ONE;
		if (sel == 2)
			return 0;
		return $urandom_range(0, ONE);
	endfunction

	// check each result against the oldest expected one
	always @(posedge clk) begin
		res_t want;
		if (arst_n && res_valid && res_ready) begin
			if (graded_q.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected result r=%0d g=%0d b=%0d",
						res.red_out, res.green_out, res.blue_out);
			end else begin
				want = graded_q.pop_front();
				if (res !== want) begin
					mismatches++;
					if (mismatches <= 10)
						$display("mismatch: want r=%0d g=%0d b=%0d got r=%0d g=%0d b=%0d",
							want.red_out, want.green_out, want.blue_out,
							res.red_out, res.green_out, res.blue_out);
				end
			end
		end
	end

	// receiver: random stalls, one long hold-off on request
	initial begin
		int stall;
		res_ready <= 1'b0;
		@(posedge arst_n);
		forever begin
			if (hold_req) begin
				res_ready <= 1'b0;
				repeat (HOLD_CYC) @(posedge clk);
				hold_req = 1'b0;
			end else if (idle_on && $urandom_range(0, 4) == 0) begin
				stall = $urandom_range(1, 10);
				res_ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end else begin
				res_ready <= 1'b1;
				@(posedge clk);
			end
		end
	end

	// watchdog
	initial begin
		cycles = 0;
		forever begin
			@(posedge clk);
			cycles++;
			if (cycles > MAX_CYC) begin
				$display("*** FAILED ***");
				$finish;
			end
		end
	end

	initial begin
		stim_row_t rows [15];
		res_t none;
		bit   held, paused;
		int   sel;
		none       = '0;
		mismatches = 0;
		sent       = 0;
		idle_on    = 1'b1;
		hold_req   = 1'b0;
		held       = 1'b0;
		paused     = 1'b0;
		arst_n     = 1'b0;
		req_valid  = 1'b0;
		req        = '0;
		for (int i = 0; i < ENTRIES; i++) begin
			lut_r[i] = '0;
			lut_g[i] = '0;
			lut_b[i] = '0;
			lut_set[i] = 1'b0;
		end

		// directed rows: origin cube, top corner, clamping and saturation
		rows[0]  = '{mk_write(0, 0, ONE, 8191), 1'b0, none};
		rows[1]  = '{mk_write(1, 100, 200, 300), 1'b0, none};
		rows[2]  = '{mk_write(16, 4000, 0, 4096), 1'b0, none};
		rows[3]  = '{mk_write(17, 5000, 1234, 77), 1'b0, none};
		rows[4]  = '{mk_write(256, 4095, 4095, 4095), 1'b0, none};
		rows[5]  = '{mk_write(257, 1, 2, 3), 1'b0, none};
		rows[6]  = '{mk_write(272, 2048, 1024, 512), 1'b0, none};
		rows[7]  = '{mk_write(273, 4096, 4096, 4096), 1'b0, none};
		rows[8]  = '{mk_pixel(0, 0, 0), 1'b1, mk_res(0, ONE, ONE)};
		rows[9]  = '{mk_write(ENTRIES - 1, 8191, 8191, 8191), 1'b0, none};
		rows[10] = '{mk_pixel(65535, 65535, 65535), 1'b1, mk_res(ONE, ONE, ONE)};
		rows[11] = '{mk_pixel(ONE, ONE, ONE), 1'b1, mk_res(ONE, ONE, ONE)};
		rows[12] = '{mk_pixel(ONE + 1, 32768, 65535), 1'b1, mk_res(ONE, ONE, ONE)};
		rows[13] = '{mk_pixel(100, 200, 273), 1'b0, none};
		rows[14] = '{mk_pixel(273, 273, 273), 1'b0, none};

		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (rows[i])
			send_item(rows[i].item, rows[i].typed, rows[i].want);

		// random part: mostly valid pixels, some overwrites and stray writes
		while (sent < N_ITEMS) begin
			if (!held && sent > 500) begin
				held = 1'b1;
				hold_req = 1'b1;
			end
			if (!paused && sent > 800) begin
				paused = 1'b1;
				req_valid <= 1'b0;
				do @(posedge clk); while (graded_q.size() != 0);
			end
			if (sent > N_ITEMS - 300)
				idle_on = 1'b0;
			sel = $urandom_range(0, 19);
			if (sel < 3)
				send_item(mk_write($urandom_range(0, ENTRIES - 1), $urandom_range(0, 8191),
					$urandom_range(0, 8191), $urandom_range(0, 8191)), 1'b0, none);
			else
				send_pixel_safe(mk_pixel(rand_chan(), rand_chan(), rand_chan()));
		end
		req_valid <= 1'b0;

		while (graded_q.size() != 0) @(posedge clk);
		repeat (DRAIN_CYC) @(posedge clk);
		if (mismatches == 0 && graded_q.size() == 0) begin
			$display("*** PASSED ***");
		end else begin
			$display("*** FAILED ***");
		end
		$finish;
	end

endmodule
